### hw/rtl/rra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle region allocator package
// Shared rectangle record, queue operation types, codes and state encoding.
// ----------------------------------------------------------------------------
package rra_pkg;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [12:0] w;
		logic [12:0] h;
	} area_t;

	typedef struct packed {
		logic  clear;
		logic  pop;
		logic  push;
		logic  front;
		area_t data;
	} qop_t;

	typedef struct packed {
		logic front;
		logic write;
		logic shift;
	} csel_t;

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_RESET   = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOFIT     = 3'd1;
	localparam logic [2:0] ST_NOINIT    = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOTALLOC  = 3'd4;

	localparam logic       CFG_WIDTH    = 1'b0;
	localparam logic       CFG_HEIGHT   = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_A_SCAN,
		S_A_SPLIT,
		S_A_RIGHT,
		S_A_DOWN,
		S_R_SCAN,
		S_R_DROP,
		S_R_FRONT,
		S_J_FIND,
		S_J_APPLY,
		S_FIN
	} state_t;

endpackage
`default_nettype wire

### hw/rtl/rra_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle region allocator cell
// One table entry; shifts toward either neighbor or loads new data.
// ----------------------------------------------------------------------------
module rra_cell
	import rra_pkg::*;
(
	input  wire logic  clk,
	input  wire csel_t sel,
	input  wire area_t prev,
	input  wire area_t nxt,
	input  wire area_t data,
	output area_t      q
);

	area_t ent_q;

	always_ff @(posedge clk) begin
		if (sel.front) begin
			ent_q <= prev;
		end else if (sel.write) begin
			ent_q <= data;
		end else if (sel.shift) begin
			ent_q <= nxt;
		end
	end

	assign q = ent_q;

endmodule
`default_nettype wire

### hw/rtl/rra_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle region allocator chain
// Ordered queue of cells with pop at the head, push at the tail or front.
// ----------------------------------------------------------------------------
module rra_chain
	import rra_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire qop_t                         op,
	output area_t                             head,
	output logic [$clog2(DEPTH+1)-1:0]        count
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] n_base;
	logic [CW-1:0] wpos;
	area_t         ent [DEPTH];

	assign n_base = op.clear ? '0 : count_q;
	assign wpos   = op.pop ? n_base - CW'(1) : n_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= n_base + CW'(op.push | op.front) - CW'(op.pop);
		end
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		csel_t sel;
		area_t prev;
		area_t nxt;
		assign sel.front = op.front;
		assign sel.write = op.push && !op.front && (wpos == CW'(k));
		assign sel.shift = op.pop;
		if (k == 0) begin : g_first
			assign prev = op.data;
		end else begin : g_mid
			assign prev = ent[k-1];
		end
		if (k == DEPTH - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_inner
			assign nxt = ent[k+1];
		end
		rra_cell u_cell (
			.clk  (clk),
			.sel  (sel),
			.prev (prev),
			.nxt  (nxt),
			.data (op.data),
			.q    (ent[k])
		);
	end

	assign head  = ent[0];
	assign count = count_q;

endmodule
`default_nettype wire

### hw/rtl/rect_region_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle region allocator
// Guillotine packer over ordered free and allocated rectangle tables.
// ----------------------------------------------------------------------------
// Both tables are rows of cells that rotate through their head, so every scan
// visits each occupied entry in turn. A reset clears both tables and loads one
// free rectangle of the configured area. An allocate scans the free table and,
// when an entry must be split, rotates it again to drop that entry and pushes
// the right and lower remainders. A release scans and then rotates the
// allocated table, puts the released rectangle at the free table's front, and
// searches the free table again after each merge until no neighbor joins. One
// transaction is processed at a time; the next one is taken once the result is registered.
module rect_region_allocator
	import rra_pkg::*;
#(
	parameter int MAX_FREE  = 64,
	parameter int MAX_ALLOC = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// cmd, req_x, req_y, req_width, req_height, zero pad
	input  wire logic [55:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status, out_x, out_y, out_width, out_height, zero pad
	output logic [55:0]      m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data
);

	localparam int FCW  = $clog2(MAX_FREE + 1);
	localparam int ACW  = $clog2(MAX_ALLOC + 1);
	localparam int MAXQ = (MAX_FREE > MAX_ALLOC) ? MAX_FREE : MAX_ALLOC;
	localparam int IW   = $clog2(MAXQ + 1);

	state_t          state_q, state_d;
	qop_t            fop, aop;
	area_t           fhead, ahead;
	logic [FCW-1:0]  free_n;
	logic [ACW-1:0]  alloc_n;

	logic [12:0]     aw_q, ah_q;
	logic            init_q;
	logic [1:0]      cmd_q;
	area_t           r_q;
	logic [IW-1:0]   idx_q, len_q, best_q, ai_q, t_q, ji_q;
	area_t           b_q, g_q, jm_q;
	logic            found_q, have_q, jf_q;
	logic [2:0]      res_st_q;
	area_t           res_a_q;
	logic            m_valid_q;
	logic [55:0]     m_data_q;

	logic            last, room, ffull;
	logic            fit_ex, fit_h, fit_w, any_fit, dom_take, have_next;
	logic            match, jhit, vert, horz, jv1, jv2, jh1, jh2;
	area_t           c, jm;
	logic [12:0]     cw_clamp, ch_clamp;
	logic [13:0]     c_xr, g_xr, c_yb, g_yb;

	assign c      = fhead;
	assign last   = (idx_q == len_q - IW'(1));
	assign room   = (alloc_n != ACW'(MAX_ALLOC));
	assign ffull  = (free_n == FCW'(MAX_FREE));

	assign cw_clamp = (aw_q == 13'd0) ? 13'd1 :
		((aw_q[12] && aw_q[11:0] != 12'd0) ? 13'd4096 : aw_q);
	assign ch_clamp = (ah_q == 13'd0) ? 13'd1 :
		((ah_q[12] && ah_q[11:0] != 12'd0) ? 13'd4096 : ah_q);

	assign fit_ex   = (c.w == r_q.w) && (c.h == r_q.h);
	assign fit_h    = (c.w == r_q.w) && (c.h >= r_q.h);
	assign fit_w    = (c.w >= r_q.w) && (c.h == r_q.h);
	assign any_fit  = !found_q && (fit_h || fit_w);
	assign dom_take = !found_q && !(fit_h || fit_w) && (c.w >= r_q.w) && (c.h >= r_q.h)
		&& (!have_q || (c.w <= b_q.w && c.h <= b_q.h));
	assign have_next = have_q || dom_take;

	assign match = !found_q && (ahead == r_q);

	assign c_xr = 14'(c.x) + 14'(c.w);
	assign g_xr = 14'(g_q.x) + 14'(g_q.w);
	assign c_yb = 14'(c.y) + 14'(c.h);
	assign g_yb = 14'(g_q.y) + 14'(g_q.h);
	assign vert = (c.x == g_q.x) && (c_xr == g_xr);
	assign jv1  = vert && (14'(c.y) == g_yb);
	assign jv2  = vert && (c_yb == 14'(g_q.y));
	assign horz = (c.y == g_q.y) && (c_yb == g_yb);
	assign jh1  = horz && (14'(c.x) == g_xr);
	assign jh2  = horz && (c_xr == 14'(g_q.x));
	assign jhit = !jf_q && (idx_q != t_q) && (jv1 || jv2 || jh1 || jh2);

	always_comb begin
		jm = c;
		if (jv1) begin
			jm.y = g_q.y;
			jm.h = c.h + g_q.h;
		end else if (jv2) begin
			jm.h = c.h + g_q.h;
		end else if (jh1) begin
			jm.x = g_q.x;
			jm.w = c.w + g_q.w;
		end else if (jh2) begin
			jm.w = c.w + g_q.w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		fop     = '0;
		aop     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_FIN;
				case (cmd_q)
					CMD_RESET: begin
						fop.clear = 1'b1;
						fop.push  = 1'b1;
						fop.data  = '{x: 12'd0, y: 12'd0, w: cw_clamp, h: ch_clamp};
						aop.clear = 1'b1;
					end
					CMD_ALLOC: begin
						if (init_q && r_q.w != 13'd0 && r_q.h != 13'd0 && free_n != '0) begin
							state_d = S_A_SCAN;
						end
					end
					CMD_RELEASE: begin
						if (init_q && alloc_n != '0) begin
							state_d = S_R_SCAN;
						end
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_A_SCAN: begin
				fop.pop  = 1'b1;
				fop.push = 1'b1;
				fop.data = c;
				if (any_fit && room) begin
					aop.push = 1'b1;
					aop.data = '{x: c.x, y: c.y, w: r_q.w, h: r_q.h};
					if (fit_ex) begin
						fop.push = 1'b0;
					end else if (fit_h) begin
						fop.data.y = c.y + r_q.h[11:0];
						fop.data.h = c.h - r_q.h;
					end else begin
						fop.data.x = c.x + r_q.w[11:0];
						fop.data.w = c.w - r_q.w;
					end
				end
				if (last) begin
					if (found_q || any_fit || !have_next || !room || ffull) begin
						state_d = S_FIN;
					end else begin
						state_d = S_A_SPLIT;
					end
				end
			end
			S_A_SPLIT: begin
				fop.pop  = 1'b1;
				fop.push = (idx_q != best_q);
				fop.data = c;
				if (last) begin
					state_d = S_A_RIGHT;
				end
			end
			S_A_RIGHT: begin
				fop.push = 1'b1;
				fop.data = '{x: b_q.x + r_q.w[11:0], y: b_q.y, w: b_q.w - r_q.w, h: r_q.h};
				state_d  = S_A_DOWN;
			end
			S_A_DOWN: begin
				fop.push = 1'b1;
				fop.data = '{x: b_q.x, y: b_q.y + r_q.h[11:0], w: b_q.w, h: b_q.h - r_q.h};
				aop.push = 1'b1;
				aop.data = '{x: b_q.x, y: b_q.y, w: r_q.w, h: r_q.h};
				state_d  = S_FIN;
			end
			S_R_SCAN: begin
				aop.pop  = 1'b1;
				aop.push = 1'b1;
				aop.data = ahead;
				if (last) begin
					state_d = ((found_q || match) && !ffull) ? S_R_DROP : S_FIN;
				end
			end
			S_R_DROP: begin
				aop.pop  = 1'b1;
				aop.push = (idx_q != ai_q);
				aop.data = ahead;
				if (last) begin
					state_d = S_R_FRONT;
				end
			end
			S_R_FRONT: begin
				fop.front = 1'b1;
				fop.data  = r_q;
				state_d   = S_J_FIND;
			end
			S_J_FIND: begin
				fop.pop  = 1'b1;
				fop.push = 1'b1;
				fop.data = c;
				if (last) begin
					state_d = (jf_q || jhit) ? S_J_APPLY : S_FIN;
				end
			end
			S_J_APPLY: begin
				fop.pop  = 1'b1;
				fop.push = (idx_q != t_q);
				fop.data = (idx_q == ji_q) ? jm_q : c;
				if (last) begin
					state_d = S_J_FIND;
				end
			end
			S_FIN: begin
				if (!m_valid_q || m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q    <= 13'd1024;
			ah_q    <= 13'd1024;
			init_q  <= 1'b0;
			found_q <= 1'b0;
			have_q  <= 1'b0;
			jf_q    <= 1'b0;
			idx_q   <= '0;
			len_q   <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_HEIGHT) begin
					ah_q <= cfg_data;
				end else begin
					aw_q <= cfg_data;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q <= s_tdata[1:0];
						r_q   <= '{x: s_tdata[13:2], y: s_tdata[25:14],
							w: s_tdata[38:26], h: s_tdata[51:39]};
					end
				end
				S_DISPATCH: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					have_q  <= 1'b0;
					jf_q    <= 1'b0;
					res_a_q <= '0;
					case (cmd_q)
						CMD_RESET: begin
							init_q   <= 1'b1;
							res_st_q <= ST_OK;
						end
						CMD_ALLOC: begin
							len_q <= IW'(free_n);
							if (!init_q) begin
								res_st_q <= ST_NOINIT;
							end else begin
								res_st_q <= ST_NOFIT;
							end
						end
						CMD_RELEASE: begin
							len_q <= IW'(alloc_n);
							if (!init_q) begin
								res_st_q <= ST_NOINIT;
							end else begin
								res_st_q <= ST_NOTALLOC;
							end
						end
						default: begin
							res_st_q <= ST_NOFIT;
						end
					endcase
				end
				S_A_SCAN: begin
					idx_q <= last ? '0 : idx_q + IW'(1);
					if (any_fit) begin
						found_q <= 1'b1;
						if (room) begin
							res_st_q <= ST_OK;
							res_a_q  <= '{x: c.x, y: c.y, w: r_q.w, h: r_q.h};
						end else begin
							res_st_q <= ST_FULL;
						end
					end else if (dom_take) begin
						best_q <= idx_q;
						b_q    <= c;
						have_q <= 1'b1;
					end
					if (last && !found_q && !any_fit && have_next) begin
						res_st_q <= ST_FULL;
					end
				end
				S_A_SPLIT: begin
					idx_q <= last ? '0 : idx_q + IW'(1);
				end
				S_A_DOWN: begin
					res_st_q <= ST_OK;
					res_a_q  <= '{x: b_q.x, y: b_q.y, w: r_q.w, h: r_q.h};
				end
				S_R_SCAN: begin
					idx_q <= last ? '0 : idx_q + IW'(1);
					if (match) begin
						found_q <= 1'b1;
						ai_q    <= idx_q;
					end
					if (last && (found_q || match)) begin
						res_st_q <= ST_FULL;
					end
				end
				S_R_DROP: begin
					idx_q <= last ? '0 : idx_q + IW'(1);
				end
				S_R_FRONT: begin
					t_q      <= '0;
					g_q      <= r_q;
					idx_q    <= '0;
					len_q    <= IW'(free_n) + IW'(1);
					jf_q     <= 1'b0;
					res_st_q <= ST_OK;
					res_a_q  <= '0;
				end
				S_J_FIND: begin
					idx_q <= last ? '0 : idx_q + IW'(1);
					if (jhit) begin
						jf_q <= 1'b1;
						ji_q <= idx_q;
						jm_q <= jm;
					end
				end
				S_J_APPLY: begin
					idx_q <= last ? '0 : idx_q + IW'(1);
					if (last) begin
						t_q   <= (ji_q > t_q) ? ji_q - IW'(1) : ji_q;
						g_q   <= jm_q;
						jf_q  <= 1'b0;
						len_q <= len_q - IW'(1);
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_FIN && (!m_valid_q || m_tready)) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!m_valid_q || m_tready)) begin
			m_data_q <= {3'b000, res_a_q.h, res_a_q.w, res_a_q.y, res_a_q.x, res_st_q};
		end
	end

	rra_chain #(.DEPTH(MAX_FREE)) u_free (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (fop),
		.head   (fhead),
		.count  (free_n)
	);

	rra_chain #(.DEPTH(MAX_ALLOC)) u_alloc (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (aop),
		.head   (ahead),
		.count  (alloc_n)
	);

	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign cfg_ready = 1'b1;

endmodule
`default_nettype wire
